// ===== hw/rtl/gc_cmt_pkg.sv =====
// ----------------------------------------------------------------------------
// gc_cmt_pkg
// Shared types, constants and helpers of the granule crossing map table.
// ----------------------------------------------------------------------------
`default_nettype none

package gc_cmt_pkg;

  // Table geometry. Granules are a power of two in size.
  localparam int unsigned MapEntriesDef = 1024;
  localparam int unsigned GranShift     = 9;
  localparam int unsigned GranuleBytes  = 1 << GranShift;
  localparam int unsigned AlignShift    = 3;
  localparam int unsigned MaxOffset     = 255;
  localparam int unsigned OffW          = 8;
  localparam int unsigned EntryW        = OffW + 2;
  localparam int unsigned WordW         = GranShift - AlignShift;

  // Granule numbers are carried wide enough for the last byte of any object.
  localparam int unsigned GW = 33 - GranShift;

  localparam int unsigned InDataW  = 200;
  localparam int unsigned OutDataW = 40;

  typedef enum logic [1:0] {
    ST_UNINIT  = 2'd0,
    ST_INIT    = 2'd1,
    ST_CROSSED = 2'd2,
    ST_BOTH    = 2'd3
  } entry_st_e;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_FIND   = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  typedef logic [OffW-1:0] off_t;

  function automatic off_t sat_inc(input off_t v);
    sat_inc = (v < off_t'(MaxOffset)) ? v + off_t'(1) : v;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/gc_cmt_ram.sv =====
// ----------------------------------------------------------------------------
// gc_cmt_ram
// Generic single write, single read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module gc_cmt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/gc_crossing_map_table_top.sv =====
// ----------------------------------------------------------------------------
// gc_crossing_map_table_top
// Granule crossing map: add, remove and find objects in a granule table.
// ----------------------------------------------------------------------------
// The table lives in one RAM with a registered read, and a sequencer
// reads, modifies and writes it one entry at a time. After reset a clearing
// pass writes every entry before the first word is accepted. An add writes
// the first granule, marks the middle granules crossed and writes the last;
// a remove clears the object's entries, marks the first granule of the next
// object and may repair the spill of the previous object; a find scans
// granules and walks back through crossed entries. Results leave through an
// output register, so a new word is taken while the last result waits.
`default_nettype none

module gc_crossing_map_table_top #(
  parameter int unsigned MAP_ENTRIES = gc_cmt_pkg::MapEntriesDef
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [31:0]                     cfg_wdata_i,   // heap_base
  input  wire logic                            s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // addr[31:0] obj_size[63:32] next_addr[95:64] has_next[96] prev_addr[128:97]
  // prev_size[160:129] has_prev[161] range_end[193:162]
  input  wire logic [gc_cmt_pkg::InDataW-1:0]  s_axis_tdata_i,
  input  wire logic [1:0]                      s_axis_tuser_i, // action[1:0]
  output logic                                 m_axis_tvalid_o,
  input  wire logic                            m_axis_tready_i,
  // found[0] object_addr[32:1] status[33]
  output logic [gc_cmt_pkg::OutDataW-1:0]      m_axis_tdata_o
);

  import gc_cmt_pkg::*;

  localparam int unsigned IdxW = $clog2(MAP_ENTRIES);

  typedef enum logic [15:0] {
    S_CLEAR   = 16'h0001,
    S_IDLE    = 16'h0002,
    S_PREP    = 16'h0004,
    S_ADD_WF  = 16'h0008,
    S_ADD_MID = 16'h0010,
    S_ADD_WL  = 16'h0020,
    S_RM_F    = 16'h0040,
    S_RM_CLR  = 16'h0080,
    S_RM_N    = 16'h0100,
    S_RP_RD   = 16'h0200,
    S_RP_F    = 16'h0400,
    S_RP_P    = 16'h0800,
    S_FD_RD   = 16'h1000,
    S_FD_G    = 16'h2000,
    S_WK      = 16'h4000,
    S_DONE    = 16'h8000
  } fsm_e;

  fsm_e             state_q, state_d;
  logic [IdxW-1:0]  clr_q, clr_d;
  logic [31:0]      base_q;
  action_e          op_q;
  logic [31:0]      r_q, nr_q, pr_q, re_q, size_q, psize_q;
  logic             has_next_q, has_prev_q;
  logic             rep_q, rep_d;
  logic [GW-1:0]    f_q, f_d, l_q, l_d, ng_q, ng_d, lg_q, lg_d, cur_q, cur_d;
  off_t             d_q, d_d;
  logic             fnd_q, fnd_d, st_q, st_d;
  logic [31:0]      oa_q, oa_d;
  logic             ov_q;
  logic [31:0]      ores_addr_q;
  logic             ores_fnd_q, ores_st_q;

  logic             accept, deliver;
  logic             ram_we, ram_re;
  logic [IdxW-1:0]  ram_waddr, ram_raddr;
  logic [EntryW-1:0] ram_wdata, ram_rdata;
  entry_st_e        rd_st;
  off_t             rd_off, off_r, off_nr;
  logic [32:0]      last_r, last_p;
  logic [GW-1:0]    pf, pl, gs, ge, map_max, map_n;
  logic [GW-1:0]    rd_off_g;
  logic [31:0]      addr_res;

  assign map_n   = GW'(MAP_ENTRIES);
  assign map_max = GW'(MAP_ENTRIES - 1);
  assign rd_st   = entry_st_e'(ram_rdata[EntryW-1:OffW]);
  assign rd_off  = ram_rdata[OffW-1:0];
  assign rd_off_g = GW'(rd_off);
  assign off_r   = OffW'(r_q[GranShift-1:AlignShift]);
  assign off_nr  = OffW'(nr_q[GranShift-1:AlignShift]);
  // A size of zero counts as one byte.
  assign last_r  = {1'b0, r_q} + ((size_q == '0) ? 33'd0 : {1'b0, size_q} - 33'd1);
  assign last_p  = {1'b0, pr_q} + ((psize_q == '0) ? 33'd0 : {1'b0, psize_q} - 33'd1);
  assign pf      = GW'(pr_q[31:GranShift]);
  assign pl      = last_p[32:GranShift];
  assign gs      = GW'(r_q[31:GranShift]);
  assign ge      = GW'(re_q[31:GranShift]);
  assign addr_res = base_q + 32'({cur_q, {GranShift{1'b0}}}) +
                    32'({rd_off, {AlignShift{1'b0}}});

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign accept  = s_axis_tvalid_i && s_axis_tready_o;
  assign deliver = (state_q == S_DONE) && (!ov_q || m_axis_tready_i);

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    rep_d     = rep_q;
    f_d       = f_q;
    l_d       = l_q;
    ng_d      = ng_q;
    lg_d      = lg_q;
    cur_d     = cur_q;
    d_d       = d_q;
    fnd_d     = fnd_q;
    st_d      = st_q;
    oa_d      = oa_q;
    ram_we    = 1'b0;
    ram_waddr = cur_q[IdxW-1:0];
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = cur_q[IdxW-1:0];
    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        clr_d     = clr_q + IdxW'(1);
        if (clr_q == IdxW'(MAP_ENTRIES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          fnd_d   = 1'b0;
          st_d    = 1'b0;
          oa_d    = '0;
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        f_d   = gs;
        l_d   = last_r[32:GranShift];
        ng_d  = GW'(nr_q[31:GranShift]);
        rep_d = has_prev_q && (pl == gs) && (pf != gs);
        cur_d = gs;
        lg_d  = (ge > map_max) ? map_max : ge;
        ram_raddr = gs[IdxW-1:0];
        case (op_q)
          ACT_ADD: begin
            if (gs >= map_n || last_r[32:GranShift] >= map_n) begin
              st_d    = 1'b1;
              state_d = S_DONE;
            end else begin
              ram_re  = 1'b1;
              state_d = S_ADD_WF;
            end
          end
          ACT_REMOVE: begin
            if (gs >= map_n || last_r[32:GranShift] >= map_n ||
                (has_next_q && GW'(nr_q[31:GranShift]) >= map_n)) begin
              st_d    = 1'b1;
              state_d = S_DONE;
            end else begin
              ram_re  = 1'b1;
              state_d = S_RM_F;
            end
          end
          ACT_FIND: begin
            if (re_q < r_q || gs > ((ge > map_max) ? map_max : ge)) begin
              state_d = S_DONE;
            end else begin
              state_d = S_FD_RD;
            end
          end
          default: state_d = S_DONE;
        endcase
      end
      S_ADD_WF: begin
        ram_waddr = f_q[IdxW-1:0];
        if (rd_st == ST_UNINIT) begin
          ram_we    = 1'b1;
          ram_wdata = {ST_INIT, off_r};
        end else if (rd_st == ST_CROSSED) begin
          ram_we    = 1'b1;
          ram_wdata = {ST_BOTH, off_r};
        end else if (rd_off > off_r) begin
          ram_we    = 1'b1;
          ram_wdata = {rd_st, off_r};
        end
        cur_d = f_q + GW'(1);
        d_d   = off_t'(1);
        state_d = (l_q == f_q) ? S_DONE : S_ADD_MID;
      end
      S_ADD_MID: begin
        if (cur_q < l_q) begin
          ram_we    = 1'b1;
          ram_wdata = {ST_CROSSED, d_q};
          cur_d     = cur_q + GW'(1);
          d_d       = sat_inc(d_q);
        end else begin
          ram_re  = 1'b1;
          state_d = S_ADD_WL;
        end
      end
      S_ADD_WL: begin
        ram_waddr = l_q[IdxW-1:0];
        if (rd_st == ST_UNINIT) begin
          ram_we    = 1'b1;
          ram_wdata = {ST_CROSSED, d_q};
        end else if (rd_st == ST_INIT) begin
          ram_we    = 1'b1;
          ram_wdata = {ST_BOTH, rd_off};
        end else begin
          st_d = 1'b1;
        end
        state_d = S_DONE;
      end
      S_RM_F: begin
        ram_waddr = f_q[IdxW-1:0];
        if ((rd_st != ST_INIT && rd_st != ST_BOTH) || rd_off > off_r) begin
          st_d    = 1'b1;
          state_d = S_DONE;
        end else begin
          ram_we  = (rd_off == off_r);
          cur_d   = f_q + GW'(1);
          state_d = S_RM_CLR;
        end
      end
      S_RM_CLR: begin
        ram_raddr = ng_q[IdxW-1:0];
        if (cur_q <= l_q) begin
          ram_we = 1'b1;
          cur_d  = cur_q + GW'(1);
        end else if (has_next_q) begin
          ram_re  = 1'b1;
          state_d = S_RM_N;
        end else begin
          state_d = rep_q ? S_RP_RD : S_DONE;
        end
      end
      S_RM_N: begin
        ram_waddr = ng_q[IdxW-1:0];
        ram_wdata = {ST_INIT, off_nr};
        ram_we    = (rd_st == ST_UNINIT);
        state_d   = rep_q ? S_RP_RD : S_DONE;
      end
      S_RP_RD: begin
        ram_re    = 1'b1;
        ram_raddr = f_q[IdxW-1:0];
        state_d   = S_RP_F;
      end
      S_RP_F: begin
        ram_waddr = f_q[IdxW-1:0];
        ram_raddr = f_q[IdxW-1:0] - IdxW'(1);
        state_d   = S_DONE;
        if (rd_st == ST_UNINIT) begin
          if (f_q == '0) begin
            st_d = 1'b1;
          end else begin
            ram_re  = 1'b1;
            state_d = S_RP_P;
          end
        end else if (rd_st == ST_INIT) begin
          ram_we    = 1'b1;
          ram_wdata = {ST_BOTH, rd_off};
        end else begin
          st_d = 1'b1;
        end
      end
      S_RP_P: begin
        ram_waddr = f_q[IdxW-1:0];
        state_d   = S_DONE;
        if (rd_st == ST_INIT || rd_st == ST_BOTH) begin
          ram_we    = 1'b1;
          ram_wdata = {ST_CROSSED, off_t'(1)};
        end else if (rd_st == ST_CROSSED) begin
          ram_we    = 1'b1;
          ram_wdata = {ST_CROSSED, sat_inc(rd_off)};
        end else begin
          st_d = 1'b1;
        end
      end
      S_FD_RD: begin
        ram_re  = 1'b1;
        state_d = S_FD_G;
      end
      S_FD_G: begin
        case (rd_st)
          ST_UNINIT: begin
            cur_d   = cur_q + GW'(1);
            state_d = (cur_q == lg_q) ? S_DONE : S_FD_RD;
          end
          ST_INIT: begin
            fnd_d   = 1'b1;
            oa_d    = addr_res;
            state_d = S_DONE;
          end
          ST_BOTH: begin
            ram_raddr = cur_q[IdxW-1:0] - IdxW'(1);
            if (cur_q == '0) begin
              st_d    = 1'b1;
              state_d = S_DONE;
            end else begin
              ram_re  = 1'b1;
              cur_d   = cur_q - GW'(1);
              state_d = S_WK;
            end
          end
          default: begin
            ram_raddr = cur_q[IdxW-1:0] - IdxW'(rd_off);
            if (rd_off == '0 || rd_off_g > cur_q) begin
              st_d    = 1'b1;
              state_d = S_DONE;
            end else begin
              ram_re  = 1'b1;
              cur_d   = cur_q - rd_off_g;
              state_d = S_WK;
            end
          end
        endcase
      end
      S_WK: begin
        ram_raddr = cur_q[IdxW-1:0] - IdxW'(rd_off);
        if (rd_st == ST_CROSSED) begin
          if (rd_off == '0 || rd_off_g > cur_q) begin
            st_d    = 1'b1;
            state_d = S_DONE;
          end else begin
            ram_re = 1'b1;
            cur_d  = cur_q - rd_off_g;
          end
        end else if (rd_st == ST_UNINIT) begin
          st_d    = 1'b1;
          state_d = S_DONE;
        end else begin
          fnd_d   = 1'b1;
          oa_d    = addr_res;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (deliver) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      base_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      if (cfg_we_i) begin
        base_q <= cfg_wdata_i;
      end
      if (deliver) begin
        ov_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rep_q <= rep_d;
    f_q   <= f_d;
    l_q   <= l_d;
    ng_q  <= ng_d;
    lg_q  <= lg_d;
    cur_q <= cur_d;
    d_q   <= d_d;
    fnd_q <= fnd_d;
    st_q  <= st_d;
    oa_q  <= oa_d;
    if (accept) begin
      op_q       <= action_e'(s_axis_tuser_i);
      r_q        <= s_axis_tdata_i[31:0] - base_q;
      size_q     <= s_axis_tdata_i[63:32];
      nr_q       <= s_axis_tdata_i[95:64] - base_q;
      has_next_q <= s_axis_tdata_i[96];
      pr_q       <= s_axis_tdata_i[128:97] - base_q;
      psize_q    <= s_axis_tdata_i[160:129];
      has_prev_q <= s_axis_tdata_i[161];
      re_q       <= s_axis_tdata_i[193:162] - base_q;
    end
    if (deliver) begin
      ores_fnd_q  <= fnd_q;
      ores_addr_q <= oa_q;
      ores_st_q   <= st_q;
    end
  end

  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tdata_o  = {6'b0, ores_st_q, ores_addr_q, ores_fnd_q};

  gc_cmt_ram #(
    .Width(EntryW),
    .Depth(MAP_ENTRIES)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/gc_cmt_checker.sv =====
// ----------------------------------------------------------------------------
// gc_cmt_checker
// Port-level checks of the granule crossing map table, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module gc_cmt_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid_i,
  input wire logic        s_axis_tready_o,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [39:0] m_axis_tdata_o
);

  // A result word stays offered until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result word dropped or changed while stalled");

  // A located object never comes with an error status.
  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[0] |-> !m_axis_tdata_o[33])
    else $error("found and error status together");

  // Without a located object the address field is zero.
  a_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[0] |-> m_axis_tdata_o[32:1] == 32'd0)
    else $error("object address set without a find hit");

  // The block is not ready in the cycle after it accepts a word.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("ready right after an accepted word");

endmodule

bind gc_crossing_map_table_top gc_cmt_checker u_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .s_axis_tvalid_i(s_axis_tvalid_i),
  .s_axis_tready_o(s_axis_tready_o),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o)
);

`default_nettype wire
